FILE: src/tcst_pkg.sv
// tcst_pkg: sizes, command and result codes, and the compare result type
// for the timed command slot table. No dependencies.
package tcst_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BYTES = 64;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 64;
    localparam int LEN_W    = 8;
    localparam int KIND_W   = 3;
    localparam int HELD_W   = 5;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXECUTE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_END = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd5;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd3600;

    typedef struct packed {
        logic sum_le;   // a + b <= c, 33-bit, no wrap
        logic le;       // a <= c
        logic lt;       // a < c
    } t_cmp_res;

endpackage

FILE: src/tcst_cmp.sv
// tcst_cmp: shared time compare unit, used for the expiry/due test and the
// minimum search. Depends on tcst_pkg.
module tcst_cmp import tcst_pkg::*; (
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    input  logic [TIME_W-1:0] i_c,
    output t_cmp_res          o_res
);

    logic [TIME_W:0] sum;

    assign sum          = {1'b0, i_a} + {1'b0, i_b};
    assign o_res.sum_le = (sum <= {1'b0, i_c});
    assign o_res.le     = (i_a <= i_c);
    assign o_res.lt     = (i_a < i_c);

endmodule

FILE: src/tcst_store.sv
// tcst_store: slot memory for due times and handles, one write port and one
// registered read port. Depends on tcst_pkg.
module tcst_store import tcst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  logic [TIME_W-1:0]   i_wr_due,
    input  logic [HANDLE_W-1:0] i_wr_handle,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output logic [TIME_W-1:0]   o_rd_due,
    output logic [HANDLE_W-1:0] o_rd_handle
);

    logic [TIME_W-1:0]   r_due_mem    [SLOTS];
    logic [HANDLE_W-1:0] r_handle_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_due_mem[i_wr_addr]    <= i_wr_due;
            r_handle_mem[i_wr_addr] <= i_wr_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_due    <= r_due_mem[i_rd_addr];
        o_rd_handle <= r_handle_mem[i_rd_addr];
    end

endmodule

FILE: src/timed_command_slot_table.sv
// Flow: add with a free slot, clear and reject go through ST_FINAL to the registered
// result; add to a full table goes ST_MIN, ST_EVICT, ST_FINAL; tick walks ST_TICK,
// holding while the output stalls. Throughput: one item at a time; the next input
// beat can land on the edge the final result is first offered.
// Reset (synchronous, active low): table empty, window 3600, no result pending.
// Depends on tcst_pkg, tcst_cmp and tcst_store.
module timed_command_slot_table import tcst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [TIME_W-1:0]   i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [TIME_W-1:0]   i_due_time,
    input  logic [HANDLE_W-1:0] i_command_handle,
    input  logic [LEN_W-1:0]    i_command_length,
    input  logic [TIME_W-1:0]   i_current_time,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [KIND_W-1:0]   o_result_kind,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [TIME_W-1:0]   o_out_time,
    output logic [HELD_W-1:0]   o_entries_held,
    output logic                o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MIN   = 3'd1;
    localparam logic [2:0] ST_EVICT = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [2:0]          r_state,   n_state;
    logic [IDX_W-1:0]    r_idx,     n_idx;
    logic [IDX_W-1:0]    r_pick,    n_pick;
    logic [TIME_W-1:0]   r_best,    n_best;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [SLOTS-1:0]    r_valid,   n_valid;
    logic [TIME_W-1:0]   r_window;
    logic [TIME_W-1:0]   r_now,     n_now;
    logic [TIME_W-1:0]   r_due,     n_due;
    logic [HANDLE_W-1:0] r_handle,  n_handle;
    logic [KIND_W-1:0]   r_kind,    n_kind;

    logic                r_out_valid,  n_out_valid;
    logic [KIND_W-1:0]   r_out_kind,   n_out_kind;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [TIME_W-1:0]   r_out_time,   n_out_time;
    logic [CNT_W-1:0]    r_out_held,   n_out_held;
    logic                r_out_last,   n_out_last;

    logic                in_beat;
    logic                out_free;
    logic                advance;
    logic [IDX_W-1:0]    free_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [TIME_W-1:0]   wr_due;
    logic [HANDLE_W-1:0] wr_handle;
    logic [TIME_W-1:0]   rd_due;
    logic [HANDLE_W-1:0] rd_handle;
    logic [TIME_W-1:0]   cmp_b;
    logic [TIME_W-1:0]   cmp_c;
    t_cmp_res            cmp_res;

    function automatic logic [IDX_W-1:0] first_free(input logic [SLOTS-1:0] v);
        logic [IDX_W-1:0] f;
        f = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                f = IDX_W'(i);
            end
        end
        return f;
    endfunction

    assign o_ready  = (r_state == ST_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign free_idx = first_free(r_valid);

    assign cmp_b = (r_state == ST_TICK) ? r_window : '0;
    assign cmp_c = (r_state == ST_TICK) ? r_now : r_best;

    tcst_cmp u_cmp (
        .i_a   (rd_due),
        .i_b   (cmp_b),
        .i_c   (cmp_c),
        .o_res (cmp_res)
    );

    tcst_store u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_due    (wr_due),
        .i_wr_handle (wr_handle),
        .i_rd_addr   (n_idx),
        .o_rd_due    (rd_due),
        .o_rd_handle (rd_handle)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = '0;
        n_pick       = r_pick;
        n_best       = r_best;
        n_count      = r_count;
        n_valid      = r_valid;
        n_now        = r_now;
        n_due        = r_due;
        n_handle     = r_handle;
        n_kind       = r_kind;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_kind   = r_out_kind;
        n_out_handle = r_out_handle;
        n_out_time   = r_out_time;
        n_out_held   = r_out_held;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = free_idx;
        wr_due       = i_due_time;
        wr_handle    = i_command_handle;
        advance      = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_now    = i_current_time;
                    n_due    = i_due_time;
                    n_handle = i_command_handle;
                    unique case (i_command)
                        CMD_ADD: begin
                            if (i_command_length > LEN_W'(SLOT_BYTES)) begin
                                n_kind  = KIND_TOO_LONG;
                                n_state = ST_FINAL;
                            end else if (r_count >= CNT_W'(SLOTS)) begin
                                n_state = ST_MIN;
                            end else begin
                                wr_en             = 1'b1;
                                n_valid[free_idx] = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_kind            = KIND_STORED;
                                n_state           = ST_FINAL;
                            end
                        end
                        CMD_TICK: begin
                            n_state = ST_TICK;
                        end
                        CMD_CLEAR: begin
                            n_valid = '0;
                            n_count = '0;
                            n_kind  = KIND_CLEARED;
                            n_state = ST_FINAL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MIN: begin
                if (r_idx == '0 || cmp_res.lt) begin
                    n_best = rd_due;
                    n_pick = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_EVICT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EVICT: begin
                wr_en     = 1'b1;
                wr_addr   = r_pick;
                wr_due    = r_due;
                wr_handle = r_handle;
                n_kind    = KIND_EVICTED;
                n_state   = ST_FINAL;
            end
            ST_TICK: begin
                if (r_valid[r_idx]) begin
                    if (cmp_res.sum_le) begin
                        n_valid[r_idx] = 1'b0;
                        n_count        = r_count - 1'b1;
                    end else if (cmp_res.le) begin
                        if (out_free) begin
                            n_valid[r_idx] = 1'b0;
                            n_count        = r_count - 1'b1;
                            n_out_valid    = 1'b1;
                            n_out_kind     = KIND_EXECUTE;
                            n_out_handle   = rd_handle;
                            n_out_time     = rd_due;
                            n_out_held     = r_count - 1'b1;
                            n_out_last     = 1'b0;
                        end else begin
                            advance = 1'b0;
                        end
                    end
                end
                if (!advance) begin
                    n_idx = r_idx;
                end else if (r_idx == LAST_IDX) begin
                    n_kind  = KIND_TICK_END;
                    n_state = ST_FINAL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_kind;
                    n_out_handle = '0;
                    n_out_time   = '0;
                    n_out_held   = r_count;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick       <= n_pick;
        r_best       <= n_best;
        r_now        <= n_now;
        r_due        <= n_due;
        r_handle     <= n_handle;
        r_kind       <= n_kind;
        r_out_kind   <= n_out_kind;
        r_out_handle <= n_out_handle;
        r_out_time   <= n_out_time;
        r_out_held   <= n_out_held;
        r_out_last   <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_out_handle   = r_out_handle;
    assign o_out_time     = r_out_time;
    assign o_entries_held = HELD_W'(r_out_held);
    assign o_last         = r_out_last;

endmodule

FILE: src/tcst_chk.sv
// tcst_chk: port-level checks for timed_command_slot_table, and its bind.
// Depends on tcst_pkg and timed_command_slot_table.
module tcst_chk import tcst_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [CMD_W-1:0]    i_command,
    input logic                o_valid,
    input logic                i_ready,
    input logic [KIND_W-1:0]   o_result_kind,
    input logic [HANDLE_W-1:0] o_out_handle,
    input logic [TIME_W-1:0]   o_out_time,
    input logic [HELD_W-1:0]   o_entries_held,
    input logic                o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped before taken");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready &&
        (i_command == CMD_ADD || i_command == CMD_TICK || i_command == CMD_CLEAR)
        |=> !o_ready)
        else $error("input taken while command in progress");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entries_held <= HELD_W'(SLOTS))
        else $error("entries_held above table size");

    a_nonexec_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_EXECUTE
        |-> o_last && o_out_handle == '0 && o_out_time == '0)
        else $error("non-execute beat not final or carries payload");

    a_exec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_EXECUTE |-> !o_last)
        else $error("execute beat marked last");

endmodule

bind timed_command_slot_table tcst_chk u_tcst_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_command      (i_command),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_kind  (o_result_kind),
    .o_out_handle   (o_out_handle),
    .o_out_time     (o_out_time),
    .o_entries_held (o_entries_held),
    .o_last         (o_last)
);
